// ----- hdl/dpjt_pkg.sv -----
// Shared types and constants for the delayed PD joint torque core.
// Holds the item structs, the queue entry layout and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpjt_pkg;

  localparam int JOINT_W = 3;
  localparam int DELAY_W = 4;
  localparam int DATA_W  = 32;

  // Depth of the queue between the front and the back.
  localparam int FQ_DEPTH = 2;

  // Register word index of delay_ticks.
  localparam logic REG_DELAY_TICKS = 1'b0;

  localparam logic signed [DATA_W-1:0] TORQUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] TORQUE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [JOINT_W-1:0]       joint;
    logic [DATA_W-1:0]        tick_time;
    logic                     sim_reset;
    logic signed [DATA_W-1:0] pos_target;
    logic signed [DATA_W-1:0] vel_target;
    logic signed [DATA_W-1:0] stiffness;
    logic signed [DATA_W-1:0] damping;
    logic signed [DATA_W-1:0] feedforward;
    logic signed [DATA_W-1:0] measured_pos;
    logic signed [DATA_W-1:0] measured_vel;
  } dpjt_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] torque_cmd;
    logic                     saturated;
  } dpjt_out_t;

  // Item as classified by the front: joint_ok is low for a joint out of range.
  typedef struct packed {
    logic     joint_ok;
    dpjt_in_t cmd;
  } dpjt_job_t;

  // One queued command as held in the command store.
  typedef struct packed {
    logic [DATA_W-1:0]        stamp;
    logic signed [DATA_W-1:0] pos_target;
    logic signed [DATA_W-1:0] vel_target;
    logic signed [DATA_W-1:0] stiffness;
    logic signed [DATA_W-1:0] damping;
    logic signed [DATA_W-1:0] feedforward;
  } dpjt_entry_t;

  localparam int ENTRY_W = $bits(dpjt_entry_t);

endpackage

`default_nettype wire

// ----- hdl/dpjt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dpjt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dpjt_front.sv -----
// Front of the torque core: accepts items, checks the joint number and
// holds them in a short queue for the back. Depends on dpjt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpjt_front #(
  parameter int JOINT_COUNT = 6
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire dpjt_pkg::dpjt_in_t  in_data,
  output logic                     job_empty,
  input  wire logic                job_pop,
  output dpjt_pkg::dpjt_job_t      job
);

  localparam int FQ_AW = (dpjt_pkg::FQ_DEPTH > 1) ? $clog2(dpjt_pkg::FQ_DEPTH) : 1;
  localparam int FQ_CW = $clog2(dpjt_pkg::FQ_DEPTH + 1);

  dpjt_pkg::dpjt_job_t fq_mem_r [dpjt_pkg::FQ_DEPTH];
  logic [FQ_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [FQ_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [FQ_CW-1:0]    cnt_r, cnt_nxt;
  logic                push_ok, pop_ok;
  dpjt_pkg::dpjt_job_t new_job;

  assign full      = (cnt_r == FQ_CW'(dpjt_pkg::FQ_DEPTH));
  assign job_empty = (cnt_r == '0);
  assign job       = fq_mem_r[rd_ptr_r];
  assign push_ok   = push && !full;
  assign pop_ok    = job_pop && !job_empty;

  // Classify: a joint at or beyond the configured count yields a zero result.
  always_comb begin
    new_job.cmd      = in_data;
    new_job.joint_ok = (32'(in_data.joint) < JOINT_COUNT);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == FQ_AW'(dpjt_pkg::FQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == FQ_AW'(dpjt_pkg::FQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      fq_mem_r[wr_ptr_r] <= new_job;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dpjt_back.sv -----
// Back of the torque core: per-joint queue upkeep in the command store,
// then the PD multiply-add with saturation into the result register.
// Depends on dpjt_pkg and dpjt_ram.
`timescale 1ns / 1ps
`default_nettype none

module dpjt_back #(
  parameter int JOINT_COUNT = 6,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [dpjt_pkg::DELAY_W-1:0] delay_ticks,
  input  wire logic                         job_empty,
  output logic                              job_pop,
  input  wire dpjt_pkg::dpjt_job_t          job,
  output logic                              empty,
  input  wire logic                         pop,
  output dpjt_pkg::dpjt_out_t               out_data
);

  localparam int HW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int JW        = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int DEPTH_ALL = JOINT_COUNT * QUEUE_DEPTH;
  localparam int AW        = $clog2(DEPTH_ALL);
  localparam int PW        = 65;
  localparam int SW        = 51;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EV_RD   = 3'd1;
  localparam logic [2:0] S_EV_CHK  = 3'd2;
  localparam logic [2:0] S_APPEND  = 3'd3;
  localparam logic [2:0] S_HEAD_RD = 3'd4;
  localparam logic [2:0] S_MUL     = 3'd5;
  localparam logic [2:0] S_SUM     = 3'd6;

  logic [2:0]             state_r, state_nxt;
  dpjt_pkg::dpjt_job_t    job_r, job_nxt;
  logic [JW-1:0]          jidx_r, jidx_nxt;
  logic [AW-1:0]          base_r, base_nxt;
  logic [HW-1:0]          hd_r, hd_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [HW-1:0]          head_arr_r [JOINT_COUNT];
  logic [HW-1:0]          head_arr_nxt [JOINT_COUNT];
  logic [CW-1:0]          count_arr_r [JOINT_COUNT];
  logic [CW-1:0]          count_arr_nxt [JOINT_COUNT];
  logic signed [31:0]     ff_r, ff_nxt;
  logic signed [PW-1:0]   prod_p_r, prod_p_nxt;
  logic signed [PW-1:0]   prod_v_r, prod_v_nxt;
  logic                   out_valid_r, out_valid_nxt;
  dpjt_pkg::dpjt_out_t    out_r, out_nxt;

  logic [JW+dpjt_pkg::JOINT_W-1:0] joint_ext;
  logic [JW-1:0]          jidx_in;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  dpjt_pkg::dpjt_entry_t  ram_wdata;
  logic [dpjt_pkg::ENTRY_W-1:0] ram_rdata;
  dpjt_pkg::dpjt_entry_t  rd;
  dpjt_pkg::dpjt_entry_t  wr_entry;
  logic                   older;
  logic                   q_full;
  logic [HW-1:0]          hd_inc, head_a;
  logic [CW-1:0]          cnt_a;
  logic [CW:0]            slot_sum;
  logic [HW-1:0]          slot;
  logic signed [32:0]     perr, verr;
  logic signed [SW-1:0]   term_p, term_v, term_f, sum;
  logic                   sat;

  dpjt_ram #(
    .WIDTH (dpjt_pkg::ENTRY_W),
    .DEPTH (DEPTH_ALL)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd       = ram_rdata;
  assign empty    = !out_valid_r;
  assign out_data = out_r;
  assign job_pop  = (state_r == S_IDLE) && !job_empty;

  assign joint_ext = (JW + dpjt_pkg::JOINT_W)'(job.cmd.joint);
  assign jidx_in   = joint_ext[JW-1:0];

  // Stamp compare in 33 bits so that stamp plus delay never wraps.
  assign older = ({1'b0, rd.stamp} + {29'b0, delay_ticks}) < {1'b0, job_r.cmd.tick_time};

  assign hd_inc   = (hd_r == HW'(QUEUE_DEPTH - 1)) ? '0 : hd_r + 1'b1;
  assign q_full   = (cnt_r == CW'(QUEUE_DEPTH));
  assign head_a   = q_full ? hd_inc : hd_r;
  assign cnt_a    = q_full ? CW'(QUEUE_DEPTH - 1) : cnt_r;
  assign slot_sum = (CW + 1)'(head_a) + (CW + 1)'(cnt_a);
  assign slot     = (slot_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                    HW'(slot_sum - (CW + 1)'(QUEUE_DEPTH)) : HW'(slot_sum);

  always_comb begin
    wr_entry.stamp       = job_r.cmd.tick_time;
    wr_entry.pos_target  = job_r.cmd.pos_target;
    wr_entry.vel_target  = job_r.cmd.vel_target;
    wr_entry.stiffness   = job_r.cmd.stiffness;
    wr_entry.damping     = job_r.cmd.damping;
    wr_entry.feedforward = job_r.cmd.feedforward;
  end

  assign perr = {rd.pos_target[31], rd.pos_target} - {job_r.cmd.measured_pos[31],
                                                       job_r.cmd.measured_pos};
  assign verr = {rd.vel_target[31], rd.vel_target} - {job_r.cmd.measured_vel[31],
                                                       job_r.cmd.measured_vel};

  // Arithmetic shift by 16 rounds the Q32.32 products toward minus infinity.
  assign term_p = {{2{prod_p_r[PW-1]}}, prod_p_r[PW-1:16]};
  assign term_v = {{2{prod_v_r[PW-1]}}, prod_v_r[PW-1:16]};
  assign term_f = {{(SW-32){ff_r[31]}}, ff_r};
  assign sum    = term_p + term_v + term_f;
  assign sat    = !((sum[SW-1:31] == '0) || (sum[SW-1:31] == '1));

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    jidx_nxt      = jidx_r;
    base_nxt      = base_r;
    hd_nxt        = hd_r;
    cnt_nxt       = cnt_r;
    head_arr_nxt  = head_arr_r;
    count_arr_nxt = count_arr_r;
    ff_nxt        = ff_r;
    prod_p_nxt    = prod_p_r;
    prod_v_nxt    = prod_v_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = base_r + AW'(slot);
    ram_wdata     = wr_entry;
    ram_re        = 1'b0;
    ram_raddr     = base_r + AW'(hd_r);

    if (out_valid_r && pop) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          job_nxt  = job;
          jidx_nxt = jidx_in;
          base_nxt = AW'(int'(jidx_in) * QUEUE_DEPTH);
          if (job.joint_ok) begin
            hd_nxt    = job.cmd.sim_reset ? '0 : head_arr_r[jidx_in];
            cnt_nxt   = job.cmd.sim_reset ? '0 : count_arr_r[jidx_in];
            state_nxt = S_EV_RD;
          end else begin
            prod_p_nxt = '0;
            prod_v_nxt = '0;
            ff_nxt     = '0;
            state_nxt  = S_SUM;
          end
        end
      end
      S_EV_RD: begin
        if (cnt_r == '0) begin
          state_nxt = S_APPEND;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (older) begin
          hd_nxt    = hd_inc;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_EV_RD;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        // Overwrite the oldest entry when the queue is still full.
        ram_we                = 1'b1;
        hd_nxt                = head_a;
        cnt_nxt               = cnt_a + 1'b1;
        head_arr_nxt[jidx_r]  = head_a;
        count_arr_nxt[jidx_r] = cnt_a + 1'b1;
        state_nxt             = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_p_nxt = rd.stiffness * perr;
        prod_v_nxt = rd.damping * verr;
        ff_nxt     = rd.feedforward;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt      = 1'b1;
          out_nxt.saturated  = sat;
          out_nxt.torque_cmd = !sat ? sum[31:0] :
                               (sum[SW-1] ? dpjt_pkg::TORQUE_MIN : dpjt_pkg::TORQUE_MAX);
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hd_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < JOINT_COUNT; i++) begin
        head_arr_r[i]  <= '0;
        count_arr_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      hd_r        <= hd_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      head_arr_r  <= head_arr_nxt;
      count_arr_r <= count_arr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    jidx_r   <= jidx_nxt;
    base_r   <= base_nxt;
    ff_r     <= ff_nxt;
    prod_p_r <= prod_p_nxt;
    prod_v_r <= prod_v_nxt;
    out_r    <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("working queue count beyond queue depth");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    hd_r <= HW'(QUEUE_DEPTH - 1))
    else $error("working queue head beyond last slot");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_SUM)
    else $error("result register loaded outside the sum step");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.saturated) |->
      (out_r.torque_cmd == dpjt_pkg::TORQUE_MAX || out_r.torque_cmd == dpjt_pkg::TORQUE_MIN))
    else $error("saturation flagged but torque not at a rail");
`endif

endmodule

`default_nettype wire

// ----- hdl/delayed_pd_joint_torque_core.sv -----
// Top level of the delayed PD joint torque core: configuration register,
// front (accept and classify) and back (queue upkeep and PD arithmetic).
// Depends on dpjt_pkg, dpjt_front, dpjt_back and dpjt_ram.
`timescale 1ns / 1ps
`default_nettype none

// Each item carries one joint's fresh command (position and velocity target,
// stiffness, damping, feedforward, all signed Q16.16), its tick stamp and the
// measured position and velocity; each item yields exactly one result, the
// torque kp*(pos_target-pos) + kd*(vel_target-vel) + ff computed from the
// oldest command still held for that joint, clipped to 32 bits with a flag.
// Every joint keeps a circular queue of QUEUE_DEPTH commands in one shared
// RAM; sim_reset empties the joint's queue first, entries whose stamp plus
// delay_ticks lies before tick_time are dropped, then the new command goes
// in (overwriting the oldest when full). A joint number at or beyond
// JOINT_COUNT changes nothing and returns zero torque, flag clear.
// Steps: the back accepts the item, then walks the queue from its head,
// where each entry examined takes one registered RAM read of its stamp
// plus one compare and is dropped if aged; it then appends the new
// command, reads the oldest entry, multiplies and sums. An out-of-range
// joint goes straight from acceptance to the sum step. The last step holds
// while an earlier result waits unaccepted. Items are worked one at a time
// in the back; a two-entry queue in the front and the result register let
// the producer and the consumer stall independently. No clearing pass
// follows reset: the per-joint head and count registers clear at once.
// Register 0 (byte address 0): delay_ticks, 4 bits, reset 0; write only
// while the core is idle.
module delayed_pd_joint_torque_core #(
  parameter int JOINT_COUNT = 6,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                push,
  output logic                     full,
  input  wire dpjt_pkg::dpjt_in_t  in_data,
  // result channel
  output logic                     empty,
  input  wire logic                pop,
  output dpjt_pkg::dpjt_out_t      out_data,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [dpjt_pkg::DELAY_W-1:0] delay_r, delay_nxt;
  logic                         cfg_wr;
  logic                         job_empty;
  logic                         job_pop;
  dpjt_pkg::dpjt_job_t          job;

  // Complete every transfer in its access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Decode on the word index; drop writes beyond the register list.
  always_comb begin
    delay_nxt = delay_r;
    if (cfg_wr && (paddr[2] == dpjt_pkg::REG_DELAY_TICKS)) begin
      delay_nxt = pwdata[dpjt_pkg::DELAY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == dpjt_pkg::REG_DELAY_TICKS) begin
      prdata = {{(32 - dpjt_pkg::DELAY_W){1'b0}}, delay_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
    end else begin
      delay_r <= delay_nxt;
    end
  end

  // Front: accept and classify, hold up to two items for the back.
  dpjt_front #(
    .JOINT_COUNT (JOINT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job)
  );

  // Back: drop stale commands, append, read the oldest, multiply and add.
  dpjt_back #(
    .JOINT_COUNT (JOINT_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .delay_ticks (delay_r),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .job         (job),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ----- bench/dpjt_torque_checker.sv -----
// Checker for the delayed PD joint torque core: watches both queue channels
// and the register port, predicts every torque and compares it in order.
// Depends on dpjt_pkg.
`timescale 1ns / 1ps

module dpjt_torque_checker #(
  parameter int JOINTS = 6,
  parameter int DEPTH  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic                full,
  input  wire dpjt_pkg::dpjt_in_t  in_data,
  input  wire logic                empty,
  input  wire logic                pop,
  input  wire dpjt_pkg::dpjt_out_t out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  input  wire logic                pready,
  output int                       mismatches,
  output int                       pending
);

  localparam logic [2:0] DELAY_ADDR = {dpjt_pkg::REG_DELAY_TICKS, 2'b00};

  // Shadow of the per-joint command queues and the delay register.
  dpjt_pkg::dpjt_entry_t        cmd_store [JOINTS][DEPTH];
  int unsigned                  head_slot [JOINTS];
  int unsigned                  held [JOINTS];
  logic [dpjt_pkg::DELAY_W-1:0] delay_cfg;

  dpjt_pkg::dpjt_out_t torque_due [$];

  initial mismatches = 0;
  initial pending = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] torque check: %s, got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic dpjt_pkg::dpjt_out_t predict_torque(input dpjt_pkg::dpjt_in_t cmd);
    dpjt_pkg::dpjt_out_t   res;
    dpjt_pkg::dpjt_entry_t oldest;
    int unsigned           j;
    longint                perr, verr, sum;
    res = '0;
    j = cmd.joint;
    // Out-of-range joint: no state change, zero torque.
    if (j >= JOINTS) return res;
    if (cmd.sim_reset) begin
      head_slot[j] = 0;
      held[j] = 0;
    end
    // Drop commands older than the delay; the compare is 33 bits wide, no wrap.
    while (held[j] > 0 &&
           33'(cmd_store[j][head_slot[j]].stamp) + 33'(delay_cfg) < 33'(cmd.tick_time)) begin
      head_slot[j] = (head_slot[j] + 1) % DEPTH;
      held[j]--;
    end
    // Still full: overwrite the oldest.
    if (held[j] >= DEPTH) begin
      head_slot[j] = (head_slot[j] + 1) % DEPTH;
      held[j] = DEPTH - 1;
    end
    cmd_store[j][(head_slot[j] + held[j]) % DEPTH] = '{cmd.tick_time, cmd.pos_target,
        cmd.vel_target, cmd.stiffness, cmd.damping, cmd.feedforward};
    held[j]++;
    oldest = cmd_store[j][head_slot[j]];
    perr = longint'($signed(oldest.pos_target)) - longint'($signed(cmd.measured_pos));
    verr = longint'($signed(oldest.vel_target)) - longint'($signed(cmd.measured_vel));
    sum = ((longint'($signed(oldest.stiffness)) * perr) >>> 16)
        + ((longint'($signed(oldest.damping)) * verr) >>> 16)
        + longint'($signed(oldest.feedforward));
    if (sum > longint'(dpjt_pkg::TORQUE_MAX)) begin
      res.torque_cmd = dpjt_pkg::TORQUE_MAX;
      res.saturated  = 1'b1;
    end else if (sum < longint'(dpjt_pkg::TORQUE_MIN)) begin
      res.torque_cmd = dpjt_pkg::TORQUE_MIN;
      res.saturated  = 1'b1;
    end else begin
      res.torque_cmd = sum[31:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    dpjt_pkg::dpjt_out_t want;
    dpjt_pkg::dpjt_out_t due;
    if (!rst_n) begin
      delay_cfg = '0;
      for (int j = 0; j < JOINTS; j++) begin
        head_slot[j] = 0;
        held[j] = 0;
      end
      torque_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == DELAY_ADDR)
        delay_cfg = pwdata[dpjt_pkg::DELAY_W-1:0];
      if (push && !full) begin
        due = predict_torque(in_data);
        torque_due = {torque_due, due};
      end
      if (pop && !empty) begin
        if (torque_due.size() == 0) begin
          report_mismatch("result with nothing expected", out_data.torque_cmd, 0);
        end else begin
          want = torque_due.pop_front();
          if (out_data.torque_cmd !== want.torque_cmd)
            report_mismatch("torque_cmd", $signed(out_data.torque_cmd),
                            $signed(want.torque_cmd));
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", out_data.saturated, want.saturated);
        end
      end
    end
    pending <= torque_due.size();
  end

endmodule

// ----- bench/tb_delayed_pd_joint_torque_core.sv -----
// Testbench top for the delayed PD joint torque core: clock, reset, stimulus
// on both queue channels and the register port, watchdog and verdict.
// Depends on dpjt_pkg, delayed_pd_joint_torque_core and dpjt_torque_checker.
`timescale 1ns / 1ps

module tb_delayed_pd_joint_torque_core;

  localparam int JOINTS     = 6;
  localparam int DEPTH      = 16;
  // Cycles without any transfer before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  // Quiet cycles after the last result: well beyond the slowest item.
  localparam int SETTLE     = 48;
  localparam logic [2:0] DELAY_ADDR = {dpjt_pkg::REG_DELAY_TICKS, 2'b00};
  // 8.0 in Q16.16, the largest magnitude of the ordinary random values.
  localparam logic signed [31:0] Q_EIGHT = 32'sh0008_0000;
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                pop = 1'b0;
  dpjt_pkg::dpjt_in_t  in_data = '0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic                full, empty, pready;
  dpjt_pkg::dpjt_out_t out_data;
  logic [31:0]         prdata;

  int fails, pending;
  int idle_cycles = 0;
  // When set, neither side idles.
  bit calm = 1'b0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  delayed_pd_joint_torque_core #(
    .JOINT_COUNT(JOINTS),
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk, .rst_n,
    .push, .full, .in_data,
    .empty, .pop, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dpjt_torque_checker #(
    .JOINTS(JOINTS),
    .DEPTH(DEPTH)
  ) u_checker (
    .clk, .rst_n,
    .push, .full, .in_data,
    .empty, .pop, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches(fails),
    .pending(pending)
  );

  // Result side: ready to take a transfer with a chance of about 79 in a hundred.
  always @(posedge clk) begin
    pop <= rst_n && (calm || $urandom_range(99) >= 21);
  end

  // Watchdog: count cycles in which no transfer of any kind happens.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly small Q16.16 values, with full-range words and the extremes mixed in
  // so that every bit toggles and saturation is reached.
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(9))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(3))
          0: return dpjt_pkg::TORQUE_MIN;
          1: return dpjt_pkg::TORQUE_MAX;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      default: return int'($urandom_range(0, 2 * Q_EIGHT)) - Q_EIGHT;
    endcase
  endfunction

  function automatic dpjt_pkg::dpjt_in_t cmd_of(input int joint,
                                                input logic [31:0] tick, input logic clear,
                                                input logic signed [31:0] pos_t, vel_t,
                                                input logic signed [31:0] kp, kd, ff,
                                                input logic signed [31:0] pos_m, vel_m);
    dpjt_pkg::dpjt_in_t cmd;
    cmd.joint        = joint[dpjt_pkg::JOINT_W-1:0];
    cmd.tick_time    = tick;
    cmd.sim_reset    = clear;
    cmd.pos_target   = pos_t;
    cmd.vel_target   = vel_t;
    cmd.stiffness    = kp;
    cmd.damping      = kd;
    cmd.feedforward  = ff;
    cmd.measured_pos = pos_m;
    cmd.measured_vel = vel_m;
    return cmd;
  endfunction

  // Offer one item and hold it until the transfer. Push stays high on return
  // so back-to-back items need no second assignment in the same step.
  task automatic send_item(input dpjt_pkg::dpjt_in_t cmd);
    while (!calm && $urandom_range(99) < 21) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (full);
  endtask

  // Stop offering, wait for every expected result, then let the core settle.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write with random upper bits, which the core must ignore.
  task automatic set_delay(input logic [dpjt_pkg::DELAY_W-1:0] value);
    logic [31:0] word;
    drain();
    word = $urandom();
    word[dpjt_pkg::DELAY_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DELAY_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random traffic in stretches: either spread over all joints with time
  // advancing (drops, sometimes many at once), or a burst on one joint with
  // time mostly held (queue fills and overwrites). A little noise on top.
  task automatic run_phase(input int count);
    logic [31:0]        now;
    int                 n, mode, focus, left, jsel;
    dpjt_pkg::dpjt_in_t cmd;
    now  = $urandom();
    left = 0;
    for (n = 0; n < count; n++) begin
      if (left == 0) begin
        mode  = $urandom_range(1);
        focus = $urandom_range(JOINTS - 1);
        left  = $urandom_range(10, 30);
      end
      left--;
      if (mode == 1)
        now += ($urandom_range(7) == 0);
      else if ($urandom_range(19) == 0)
        now += $urandom_range(20, 60);
      else
        now += $urandom_range(3);
      jsel = (mode == 1) ? focus : int'($urandom_range(JOINTS - 1));
      if ($urandom_range(19) == 0) jsel = $urandom_range(7);
      cmd = cmd_of(jsel, now,
                   $urandom_range(31) == 0, rand_q16(), rand_q16(), rand_q16(),
                   rand_q16(), rand_q16(), rand_q16(), rand_q16());
      if ($urandom_range(24) == 0) cmd.tick_time = $urandom();
      send_item(cmd);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, delay still at its reset value of zero.
    // Gain terms at full scale cancel, leaving ff at the top of the range.
    send_item(cmd_of(0, 100, 1'b0, dpjt_pkg::TORQUE_MAX, dpjt_pkg::TORQUE_MIN,
                     dpjt_pkg::TORQUE_MIN, dpjt_pkg::TORQUE_MIN, dpjt_pkg::TORQUE_MAX,
                     dpjt_pkg::TORQUE_MIN, dpjt_pkg::TORQUE_MAX));
    // Clip high, then clip low.
    send_item(cmd_of(1, 100, 1'b0, dpjt_pkg::TORQUE_MAX, 0, dpjt_pkg::TORQUE_MAX, 0, 0,
                     dpjt_pkg::TORQUE_MIN, 0));
    send_item(cmd_of(2, 100, 1'b0, dpjt_pkg::TORQUE_MIN, dpjt_pkg::TORQUE_MIN,
                     dpjt_pkg::TORQUE_MAX, dpjt_pkg::TORQUE_MAX, dpjt_pkg::TORQUE_MIN,
                     dpjt_pkg::TORQUE_MAX, dpjt_pkg::TORQUE_MAX));
    // Bottom of the range without clipping.
    send_item(cmd_of(3, 100, 1'b0, -32'sd1, -32'sd1, 0, 0, dpjt_pkg::TORQUE_MIN, 0, 0));
    // Tiny negative products round toward minus infinity.
    send_item(cmd_of(4, 100, 1'b0, -32'sd1, 32'sd3, 32'sd1, -32'sd1, 0, 0, 0));
    // Joints out of range.
    send_item(cmd_of(6, 100, 1'b0, rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                     rand_q16(), rand_q16(), rand_q16()));
    send_item(cmd_of(7, 100, 1'b1, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0));
    // Clear a joint's queue, then drop an aged entry.
    send_item(cmd_of(1, 100, 1'b1, Q_ONE, 0, Q_ONE, 0, Q_ONE, 0, 0));
    send_item(cmd_of(2, 101, 1'b0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0));
    // Same stamp seventeen times: the queue fills and the oldest is overwritten.
    for (int k = 0; k < DEPTH + 1; k++)
      send_item(cmd_of(5, 200, 1'b0, Q_ONE, -Q_ONE, Q_ONE, Q_ONE, k * Q_ONE, 0, 0));

    // Longest delay; stamps at the top of the range must not wrap in the compare.
    set_delay(4'd15);
    send_item(cmd_of(0, 32'hFFFF_FFF8, 1'b1, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0));
    send_item(cmd_of(0, 32'hFFFF_FFFF, 1'b0, 0, 0, 0, 0, Q_ONE, 0, 0));
    send_item(cmd_of(0, 32'd3, 1'b0, 0, 0, 0, 0, -Q_ONE, 0, 0));
    run_phase(100);

    set_delay(4'd0);
    run_phase(100);

    // No idling on either side for this stretch.
    set_delay(4'd7);
    calm = 1'b1;
    run_phase(100);
    calm = 1'b0;

    set_delay(4'd1);
    run_phase(100);

    set_delay(4'($urandom_range(2, 14)));
    run_phase(100);

    drain();
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
